// ===== rtl/itpt_pkg.sv =====
package itpt_pkg;

  // Sizes
  localparam int VALUE_BITS  = 64;
  localparam int MAX_FIELD   = 64;
  localparam int STORE_DEPTH = MAX_FIELD - 1;
  localparam int POS_W       = $clog2(MAX_FIELD);
  localparam int CNT_W       = $clog2(VALUE_BITS);
  localparam int FS_W        = 7;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_CHAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SIZE = 2'd2;

  // Reset values
  localparam logic [RADIX_W-1:0] RADIX_RST    = 6'd10;
  localparam logic [CHAR_W-1:0]  PAD_CHAR_RST = 8'd32;
  localparam logic [FS_W-1:0]    FS_RST       = 7'd21;

  // Limits and characters
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [FS_W-1:0]    FS_MIN     = 7'd2;
  localparam logic [FS_W-1:0]    FS_MAX     = FS_W'(MAX_FIELD);
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0]  CH_ALPHA   = 8'h41;
  localparam logic [CHAR_W-1:0]  CH_MINUS   = 8'h2D;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [POS_W-1:0]      pos_t;

  // Character for one digit value below the radix
  function automatic char_t digit_char(input logic [RADIX_W-1:0] d);
    if (d < DEC_DIGITS) begin
      return CH_ZERO + CHAR_W'(d);
    end else begin
      return CH_ALPHA + CHAR_W'(d - DEC_DIGITS);
    end
  endfunction

endpackage

// ===== rtl/itpt_if.sv =====
interface itpt_item_if;
  logic                valid;
  logic                ready;
  itpt_pkg::value_t    value;
  logic                negate;

  modport source (output valid, value, negate, input ready);
  modport sink   (input valid, value, negate, output ready);
endinterface

interface itpt_result_if;
  logic             valid;
  logic             ready;
  itpt_pkg::char_t  out_char;
  logic             is_pad;
  logic             last;
  logic             overflow_error;

  modport source (output valid, out_char, is_pad, last, overflow_error, input ready);
  modport sink   (input valid, out_char, is_pad, last, overflow_error, output ready);
endinterface

interface itpt_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [itpt_pkg::CFG_IDX_W-1:0]        index;
  logic [itpt_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/integer_to_padded_text_unit.sv =====
// Integer to padded text: converts a 64-bit value (negated first when negate
// is set) into base-radix text, right-justified in a field of field_size-1
// characters (field_size above 64 counts as 64) behind a '-' where needed and
// pad characters, and sends the field one character per transfer, marking pad
// characters and the last one. When the digits and sign do not fit, radix is
// out of range or field_size is below 2, a single transfer with
// overflow_error and last set is sent instead. One item is worked on at a
// time: each digit is produced by a bit-serial restoring division of the
// 64-bit quotient by the radix, and each character is then read from the
// character store through a registered read before it is emitted.
// Configuration writes are always taken and should be made only while the
// block is idle.
module integer_to_padded_text_unit (
  input  logic                   clk,
  input  logic                   rst,
  itpt_item_if.sink              item,
  itpt_result_if.source          result,
  itpt_cfg_if.sink               cfg
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_DIGIT = 6'b000100,
    S_ERR   = 6'b001000,
    S_RD    = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state;

  logic [itpt_pkg::RADIX_W-1:0] radix;
  itpt_pkg::char_t              pad_char;
  logic [itpt_pkg::FS_W-1:0]    field_size;

  itpt_pkg::value_t             quot;
  logic [itpt_pkg::RADIX_W-1:0] rem;
  logic [itpt_pkg::CNT_W-1:0]   cnt;
  logic                         nz;
  logic                         neg;
  itpt_pkg::pos_t               wp;
  itpt_pkg::pos_t               rd;
  itpt_pkg::pos_t               pads;
  itpt_pkg::pos_t               last_pos;

  itpt_pkg::char_t              store [itpt_pkg::STORE_DEPTH];
  itpt_pkg::char_t              store_q;

  logic                         out_free;
  logic [itpt_pkg::FS_W-1:0]    fs_sat;
  itpt_pkg::pos_t               n_chars;
  logic                         radix_ok;
  logic                         fs_ok;
  logic [itpt_pkg::RADIX_W:0]   trial;
  logic                         ge;
  logic [itpt_pkg::RADIX_W-1:0] rem_next;
  itpt_pkg::pos_t               wp_dec;
  itpt_pkg::char_t              emit_char;
  logic                         emit_pad;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign out_free   = !result.valid || result.ready;

  // Check the configuration for a new item
  assign radix_ok = (radix >= itpt_pkg::RADIX_MIN) && (radix <= itpt_pkg::RADIX_MAX);
  assign fs_ok    = (field_size >= itpt_pkg::FS_MIN);
  assign fs_sat   = (field_size > itpt_pkg::FS_MAX) ? itpt_pkg::FS_MAX : field_size;
  assign n_chars  = itpt_pkg::POS_W'(fs_sat - 7'd1);

  // One restoring division step
  assign trial    = {rem, quot[itpt_pkg::VALUE_BITS-1]};
  assign ge       = trial >= {1'b0, radix};
  assign rem_next = ge ? itpt_pkg::RADIX_W'(trial - {1'b0, radix})
                       : itpt_pkg::RADIX_W'(trial);

  assign wp_dec   = wp - itpt_pkg::POS_W'(1);

  // Pick the character for the current field position
  always_comb begin
    emit_pad  = 1'b0;
    emit_char = store_q;
    if (rd < pads) begin
      emit_pad  = 1'b1;
      emit_char = pad_char;
    end else if (neg && (rd == pads)) begin
      emit_char = itpt_pkg::CH_MINUS;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= itpt_pkg::RADIX_RST;
      pad_char   <= itpt_pkg::PAD_CHAR_RST;
      field_size <= itpt_pkg::FS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        itpt_pkg::REG_RADIX:      radix      <= cfg.data[itpt_pkg::RADIX_W-1:0];
        itpt_pkg::REG_PAD_CHAR:   pad_char   <= cfg.data;
        itpt_pkg::REG_FIELD_SIZE: field_size <= cfg.data[itpt_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  // Character store: write digits, registered read
  always_ff @(posedge clk) begin
    if (state == S_DIGIT) begin
      store[wp_dec] <= itpt_pkg::digit_char(rem);
    end
    if (state == S_RD) begin
      store_q <= store[rd];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            neg  <= item.negate;
            quot <= item.negate ? (~item.value + itpt_pkg::VALUE_BITS'(1)) : item.value;
            wp   <= n_chars;
            rem  <= '0;
            cnt  <= '0;
            nz   <= 1'b0;
            last_pos <= n_chars - itpt_pkg::POS_W'(1);
            if (!radix_ok || !fs_ok || (n_chars <= itpt_pkg::POS_W'(item.negate))) begin
              state <= S_ERR;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quot <= {quot[itpt_pkg::VALUE_BITS-2:0], ge};
          rem  <= rem_next;
          nz   <= nz | ge;
          cnt  <= cnt + itpt_pkg::CNT_W'(1);
          if (cnt == itpt_pkg::CNT_W'(itpt_pkg::VALUE_BITS - 1)) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          wp  <= wp_dec;
          rem <= '0;
          cnt <= '0;
          nz  <= 1'b0;
          if (nz) begin
            if (wp_dec > itpt_pkg::POS_W'(neg)) begin
              state <= S_DIV;
            end else begin
              state <= S_ERR;
            end
          end else begin
            pads  <= wp_dec - itpt_pkg::POS_W'(neg);
            rd    <= '0;
            state <= S_RD;
          end
        end
        S_ERR: begin
          if (out_free) begin
            result.valid          <= 1'b1;
            result.out_char       <= '0;
            result.is_pad         <= 1'b0;
            result.last           <= 1'b1;
            result.overflow_error <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            result.valid          <= 1'b1;
            result.out_char       <= emit_char;
            result.is_pad         <= emit_pad;
            result.last           <= (rd == last_pos);
            result.overflow_error <= 1'b0;
            rd                    <= rd + itpt_pkg::POS_W'(1);
            state                 <= (rd == last_pos) ? S_IDLE : S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
